### hdl/ihp_pkg.sv
// Package with the transaction types and operation codes of the indexed min-heap.
package ihp_pkg;

    localparam int VERTICES   = 256;
    localparam int SLOT_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int KEY_W      = 31;
    localparam int VTX_W      = 8;

    localparam logic [1:0] OP_FILL     = 2'd0;
    localparam logic [1:0] OP_DECREASE = 2'd1;
    localparam logic [1:0] OP_EXTRACT  = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [VTX_W-1:0]  vertex;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] count;
    } in_t;

    typedef struct packed {
        logic [VTX_W-1:0]  out_vertex;
        logic [KEY_W-1:0]  out_key;
        logic              was_empty;
        logic              in_heap;
        logic              absent_error;
        logic [SIZE_W-1:0] live_size;
    } out_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
    } slot_t;

endpackage

### hdl/ihp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/indexed_min_heap.sv
// Top level of the indexed binary min-heap with decrease-key and extract-min.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   input    | in_valid / in_ready  | in_item  (op, vertex, key, count)
//   output   | out_valid / out_ready| out_item (vertex, key, flags, size)
//
// Operation: one transaction at a time, from the accept cycle through the done
// state. Fill makes one slot write a cycle. Query reads the position RAM, then
// the slot RAM; decrease-key stops there when the vertex is absent or the key
// rises, else climbs toward the root, one parent read and move per level. Extract
// goes straight to the done state on an empty heap, else reads the root and the
// last slot and sinks the last entry level by level (two child reads on the single
// slot RAM read port, then compare and write); both end in a write-back.
// Reset clears the size and the control state only; slot and position RAMs
// hold garbage until written by fill. in_ready is high in idle even while a
// result still waits in the output register; a finished result waits in the
// done state until the output register frees up.
module indexed_min_heap
    import ihp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_RD0  = 4'd2;
    localparam logic [3:0] ST_RD1  = 4'd3;
    localparam logic [3:0] ST_RD2  = 4'd4;
    localparam logic [3:0] ST_EX0  = 4'd5;
    localparam logic [3:0] ST_EX1  = 4'd6;
    localparam logic [3:0] ST_EX2  = 4'd7;
    localparam logic [3:0] ST_SU0  = 4'd8;
    localparam logic [3:0] ST_SU1  = 4'd9;
    localparam logic [3:0] ST_SD0  = 4'd10;
    localparam logic [3:0] ST_SD1  = 4'd11;
    localparam logic [3:0] ST_SD2  = 4'd12;
    localparam logic [3:0] ST_WB   = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              out_valid_reg, out_valid_next;

    // payload and working registers
    logic [1:0]        op_reg, op_next;
    logic [VTX_W-1:0]  vtx_reg, vtx_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] last_reg, last_next;
    logic [SLOT_W-1:0] i_reg, i_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    slot_t             mv_reg, mv_next;
    slot_t             lc_reg, lc_next;
    slot_t             res_reg, res_next;
    logic              empty_reg, empty_next;
    logic              inh_reg, inh_next;
    logic              abs_reg, abs_next;
    out_t              out_reg, out_next;

    // RAM ports
    logic              s_we;
    logic [SLOT_W-1:0] s_waddr, s_raddr;
    slot_t             s_wdata, s_rdata;
    logic              p_we;
    logic [VTX_W-1:0]  p_waddr, p_raddr;
    logic [SLOT_W-1:0] p_wdata, p_rdata;

    logic [SIZE_W-1:0] fill_n;
    logic [SIZE_W-1:0] left_idx;
    logic [SIZE_W:0]   right_idx;
    logic              left_ok, right_ok, sel_left, sel_right;
    logic [KEY_W-1:0]  best_key;
    logic              live;
    logic              out_free;

    ihp_ram #(.WIDTH($bits(slot_t)), .DEPTH(VERTICES)) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ihp_ram #(.WIDTH(SLOT_W), .DEPTH(VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // clamp fill count to the heap capacity
    assign fill_n = (in_item.count > SIZE_W'(VERTICES)) ? SIZE_W'(VERTICES) : in_item.count;

    // children of the current slot; left child is tried first, strict compare
    assign left_idx  = {i_reg, 1'b1};
    assign right_idx = {1'b0, i_reg, 1'b0} + (SIZE_W+1)'(2);
    assign left_ok   = left_idx < size_reg;
    assign right_ok  = right_idx < {1'b0, size_reg};
    assign sel_left  = left_ok && (lc_reg.key < mv_reg.key);
    assign best_key  = sel_left ? lc_reg.key : mv_reg.key;
    assign sel_right = right_ok && (s_rdata.key < best_key);

    // a stale position entry is caught by checking the slot's vertex
    assign live = ({1'b0, p_reg} < size_reg) && (s_rdata.vertex == vtx_reg);

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        vtx_next       = vtx_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        mv_next        = mv_reg;
        lc_next        = lc_reg;
        res_next       = res_reg;
        empty_next     = empty_reg;
        inh_next       = inh_reg;
        abs_next       = abs_reg;
        out_next       = out_reg;

        s_we    = 1'b0;
        s_waddr = i_reg;
        s_wdata = mv_reg;
        s_raddr = '0;
        p_we    = 1'b0;
        p_waddr = mv_reg.vertex;
        p_wdata = i_reg;
        p_raddr = vtx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item.op;
                    vtx_next   = in_item.vertex;
                    key_next   = in_item.key;
                    res_next   = '0;
                    empty_next = 1'b0;
                    inh_next   = 1'b0;
                    abs_next   = 1'b0;
                    cnt_next   = '0;
                    unique case (in_item.op)
                        OP_FILL:
                        begin
                            size_next = fill_n;
                            last_next = SLOT_W'(fill_n - SIZE_W'(1));
                            state_next = (fill_n == '0) ? ST_DONE : ST_FILL;
                        end
                        OP_EXTRACT:
                        begin
                            if (size_reg == '0)
                            begin
                                empty_next = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_EX0;
                            end
                        end
                        OP_DECREASE, OP_QUERY:
                        begin
                            state_next = ST_RD0;
                        end
                        default:
                        begin
                            state_next = ST_RD0;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                s_we    = 1'b1;
                s_waddr = cnt_reg;
                s_wdata = '{vertex: cnt_reg, key: key_reg};
                p_we    = 1'b1;
                p_waddr = cnt_reg;
                p_wdata = cnt_reg;
                cnt_next = cnt_reg + SLOT_W'(1);
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD0:
            begin
                p_raddr    = vtx_reg;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                p_next     = p_rdata;
                s_raddr    = p_rdata;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                if (op_reg == OP_QUERY)
                begin
                    inh_next   = live;
                    state_next = ST_DONE;
                end
                else if (!live)
                begin
                    abs_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (key_reg <= s_rdata.key)
                begin
                    mv_next    = '{vertex: vtx_reg, key: key_reg};
                    i_next     = p_reg;
                    state_next = ST_SU0;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EX0:
            begin
                s_raddr    = '0;
                state_next = ST_EX1;
            end
            ST_EX1:
            begin
                res_next   = s_rdata;
                s_raddr    = SLOT_W'(size_reg - SIZE_W'(1));
                state_next = ST_EX2;
            end
            ST_EX2:
            begin
                mv_next    = s_rdata;
                i_next     = '0;
                size_next  = size_reg - SIZE_W'(1);
                state_next = ST_SD0;
            end
            ST_SU0:
            begin
                s_raddr = SLOT_W'((i_reg - SLOT_W'(1)) >> 1);
                state_next = (i_reg == '0) ? ST_WB : ST_SU1;
            end
            ST_SU1:
            begin
                if (mv_reg.key < s_rdata.key)
                begin
                    // move the parent down into the current slot
                    s_we    = 1'b1;
                    s_waddr = i_reg;
                    s_wdata = s_rdata;
                    p_we    = 1'b1;
                    p_waddr = s_rdata.vertex;
                    p_wdata = i_reg;
                    i_next  = SLOT_W'((i_reg - SLOT_W'(1)) >> 1);
                    state_next = ST_SU0;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_SD0:
            begin
                s_raddr    = left_idx[SLOT_W-1:0];
                state_next = left_ok ? ST_SD1 : ST_WB;
            end
            ST_SD1:
            begin
                lc_next    = s_rdata;
                s_raddr    = right_idx[SLOT_W-1:0];
                state_next = ST_SD2;
            end
            ST_SD2:
            begin
                if (sel_right || sel_left)
                begin
                    // pull the smaller child up into the current slot
                    s_we    = 1'b1;
                    s_waddr = i_reg;
                    s_wdata = sel_right ? s_rdata : lc_reg;
                    p_we    = 1'b1;
                    p_waddr = sel_right ? s_rdata.vertex : lc_reg.vertex;
                    p_wdata = i_reg;
                    i_next  = sel_right ? right_idx[SLOT_W-1:0] : left_idx[SLOT_W-1:0];
                    state_next = ST_SD0;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg;
                s_wdata    = mv_reg;
                p_we       = 1'b1;
                p_waddr    = mv_reg.vertex;
                p_wdata    = i_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.out_vertex   = res_reg.vertex;
                    out_next.out_key      = res_reg.key;
                    out_next.was_empty    = empty_reg;
                    out_next.in_heap      = inh_reg;
                    out_next.absent_error = abs_reg;
                    out_next.live_size    = size_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        vtx_reg   <= vtx_next;
        key_reg   <= key_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        mv_reg    <= mv_next;
        lc_reg    <= lc_next;
        res_reg   <= res_next;
        empty_reg <= empty_next;
        inh_reg   <= inh_next;
        abs_reg   <= abs_next;
        out_reg   <= out_next;
    end

    // the heap never grows past its capacity
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SIZE_W'(VERTICES))
        else $error("heap size above capacity");

    // one transaction at a time: input closes right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // a finished result lands in the output register once it is free
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> out_valid && in_ready)
        else $error("result not delivered from done state");

    // extract on a nonempty heap shrinks it by exactly one
    a_extract_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EX2) |=> (size_reg == $past(size_reg) - SIZE_W'(1)))
        else $error("extract did not shrink the heap");

endmodule
